// File: design/assert_macros.svh
// Assertion macros used by the frame engine back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IOFE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IOFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/iofe_pkg.sv
// Types, codes and a helper function shared by the frame engine modules.
`default_nettype none

package iofe_pkg;

    // Input item kinds as they arrive on the stream.
    localparam logic [2:0] KIND_SET  = 3'd0;
    localparam logic [2:0] KIND_READ = 3'd1;
    localparam logic [2:0] KIND_SEND = 3'd2;
    localparam logic [2:0] KIND_RXB  = 3'd3;
    localparam logic [2:0] KIND_END  = 3'd4;

    // Result kinds.
    localparam logic [1:0] RK_TX     = 2'd0;
    localparam logic [1:0] RK_BIT    = 2'd1;
    localparam logic [1:0] RK_STATUS = 2'd2;

    // Receive status codes.
    localparam logic [2:0] STS_OK    = 3'd0;
    localparam logic [2:0] STS_EMPTY = 3'd1;
    localparam logic [2:0] STS_LEN   = 3'd2;
    localparam logic [2:0] STS_TYPE  = 3'd3;
    localparam logic [2:0] STS_ADDR  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OUTPUT_COUNT    = 2'd0;
    localparam logic [1:0] CFG_INPUT_COUNT     = 2'd1;
    localparam logic [1:0] CFG_COUPLER_ADDRESS = 2'd2;

    // Frame constants.
    localparam logic [7:0] CH_REQUEST   = 8'h50;   // 'P'
    localparam logic [7:0] CH_ANSWER    = 8'h70;   // 'p'
    localparam logic [2:0] BIT_SEL_MASK = 3'h7;
    localparam logic [6:0] EVEN_MASK    = 7'h7E;
    localparam int         REQ_HDR_BYTES = 4;

    // Command queue depth.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_SET,
        OP_READ,
        OP_SEND,
        OP_RXB,
        OP_END
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_WR,
        ST_READ_RESP,
        ST_SEND,
        ST_COMMIT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] byte_num;
        logic [2:0] bit_sel;
        logic       bit_value;
        logic [7:0] rx_byte;
        logic       in_range;
    } cmd_t;

    typedef struct packed {
        logic [7:0] output_count;
        logic [7:0] input_count;
        logic [7:0] coupler_address;
    } cfg_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       input_value;
        logic [2:0] rx_status;
    } result_t;

    // Image size in bytes for a point count: whole words, capped at an even cap.
    function automatic logic [6:0] image_bytes(input logic [7:0] count,
                                               input logic [6:0] cap);
        logic [8:0] nbytes;
        logic [6:0] even;
        nbytes = ({1'b0, count} + 9'd7) >> 3;
        even   = (7'(nbytes) + 7'd1) & EVEN_MASK;
        return (even > cap) ? cap : even;
    endfunction

endpackage

`default_nettype wire

// File: design/iofe_front.sv
// Front end: accepts input requests, decodes the kind and range-checks the byte number.
`default_nettype none

module iofe_front #(
    parameter int MAX_IMAGE_BYTES = 16
) (
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,
    input  wire logic [2:0]       s_tuser,
    input  wire logic             q_full,
    output logic                  q_push,
    output iofe_pkg::cmd_t        q_cmd
);

    logic       known_kind;
    iofe_pkg::op_t op;

    always_comb begin
        known_kind = 1'b1;
        op         = iofe_pkg::OP_SET;
        unique case (s_tuser)
            iofe_pkg::KIND_SET:  op = iofe_pkg::OP_SET;
            iofe_pkg::KIND_READ: op = iofe_pkg::OP_READ;
            iofe_pkg::KIND_SEND: op = iofe_pkg::OP_SEND;
            iofe_pkg::KIND_RXB:  op = iofe_pkg::OP_RXB;
            iofe_pkg::KIND_END:  op = iofe_pkg::OP_END;
            default:             known_kind = 1'b0;
        endcase
    end

    // Unknown kinds are taken from the stream and dropped.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && known_kind;

    always_comb begin
        q_cmd.op        = op;
        q_cmd.byte_num  = s_tdata[6:3];
        q_cmd.bit_sel   = s_tdata[2:0] & iofe_pkg::BIT_SEL_MASK;
        q_cmd.bit_value = s_tdata[7];
        q_cmd.rx_byte   = s_tdata[15:8];
        q_cmd.in_range  = (32'(s_tdata[6:3]) < MAX_IMAGE_BYTES);
    end

endmodule

`default_nettype wire

// File: design/iofe_cmd_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module iofe_cmd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire iofe_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output iofe_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                empty
);

    localparam int QAW = $clog2(iofe_pkg::QUEUE_DEPTH);
    localparam int QCW = $clog2(iofe_pkg::QUEUE_DEPTH + 1);

    iofe_pkg::cmd_t   entry_reg [iofe_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == QCW'(iofe_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/iofe_back.sv
// Back end: image memories, frame sequencer, burst check and result register.
`default_nettype none
`include "assert_macros.svh"

module iofe_back #(
    parameter int MAX_IMAGE_BYTES     = 16,
    parameter int ANSWER_HEADER_BYTES = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire iofe_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire iofe_pkg::cmd_t q_head,
    output logic                q_pop,
    input  wire logic           m_tready,
    output logic                m_tvalid,
    output iofe_pkg::result_t   m_result
);

    localparam int SHADOW_DEPTH = ANSWER_HEADER_BYTES + MAX_IMAGE_BYTES + 1;
    localparam int IMG_AW  = $clog2(MAX_IMAGE_BYTES);
    localparam int SH_AW   = $clog2(SHADOW_DEPTH);
    localparam int CNT_W   = $clog2(SHADOW_DEPTH + 2);
    localparam int SIZE_W  = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int POS_W   = $clog2(MAX_IMAGE_BYTES + iofe_pkg::REQ_HDR_BYTES + 2);
    localparam logic [6:0] SIZE_CAP = 7'(MAX_IMAGE_BYTES) & iofe_pkg::EVEN_MASK;

    // Storage.
    logic [7:0]  oi_mem [MAX_IMAGE_BYTES];
    logic        oi_vld_reg [MAX_IMAGE_BYTES];
    logic [7:0]  ii_mem [MAX_IMAGE_BYTES];
    logic        ii_vld_reg [MAX_IMAGE_BYTES];
    logic [7:0]  sh_mem [SHADOW_DEPTH];
    logic [7:0]  oi_rdata_reg, ii_rdata_reg, sh_rdata_reg;

    // Sequencer state.
    iofe_pkg::state_t state_reg, state_next;
    iofe_pkg::cmd_t   cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        sum_reg;
    logic [CNT_W-1:0]  rx_cnt_reg;
    logic [7:0]        first_reg, addr_reg;
    logic [2:0]        status_reg;
    logic [SIZE_W-1:0] copy_len_reg, copy_idx_reg;
    logic              wr_pend_reg;
    logic [IMG_AW-1:0] wr_idx_reg;
    logic              out_valid_reg;
    iofe_pkg::result_t out_reg;

    // Control decoded from the state.
    logic              oi_rd_en, ii_rd_en, sh_rd_en, oi_wr_en, sh_wr_en;
    logic [IMG_AW-1:0] oi_rd_addr, ii_rd_addr, oi_wr_addr;
    logic [SH_AW-1:0]  sh_rd_addr;
    logic [7:0]        oi_wr_data;
    logic              res_push;
    iofe_pkg::result_t res;

    logic              out_free;
    logic [SIZE_W-1:0] out_size, in_size;
    logic [POS_W-1:0]  data_end, pos_inc;
    logic              send_last;
    logic [7:0]        send_byte, bit_mask;
    logic [CNT_W-1:0]  expect_cnt;
    logic [2:0]        end_status;
    logic              head_is_end, head_is_send, head_is_rxb;

    assign out_free  = !out_valid_reg || m_tready;
    assign out_size  = SIZE_W'(iofe_pkg::image_bytes(cfg.output_count, SIZE_CAP));
    assign in_size   = SIZE_W'(iofe_pkg::image_bytes(cfg.input_count, SIZE_CAP));
    assign data_end  = POS_W'(iofe_pkg::REQ_HDR_BYTES) + POS_W'(out_size);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign send_last = (pos_reg == data_end);
    assign bit_mask  = 8'(1) << cmd_reg.bit_sel;
    assign expect_cnt = CNT_W'(ANSWER_HEADER_BYTES) + CNT_W'(in_size) + CNT_W'(1);

    assign head_is_end  = !q_empty && (q_head.op == iofe_pkg::OP_END);
    assign head_is_send = !q_empty && (q_head.op == iofe_pkg::OP_SEND);
    assign head_is_rxb  = !q_empty && (q_head.op == iofe_pkg::OP_RXB);

    always_comb begin
        priority if (rx_cnt_reg == '0) begin
            end_status = iofe_pkg::STS_EMPTY;
        end else if (rx_cnt_reg != expect_cnt) begin
            end_status = iofe_pkg::STS_LEN;
        end else if (first_reg != iofe_pkg::CH_ANSWER) begin
            end_status = iofe_pkg::STS_TYPE;
        end else if (addr_reg != cfg.coupler_address) begin
            end_status = iofe_pkg::STS_ADDR;
        end else begin
            end_status = iofe_pkg::STS_OK;
        end
    end

    // Request frame byte at the current position.
    always_comb begin
        priority if (pos_reg == POS_W'(0)) begin
            send_byte = iofe_pkg::CH_REQUEST;
        end else if (pos_reg == POS_W'(1)) begin
            send_byte = 8'(out_size >> 1);
        end else if (pos_reg < POS_W'(iofe_pkg::REQ_HDR_BYTES)) begin
            send_byte = cfg.coupler_address;
        end else if (pos_reg < data_end) begin
            send_byte = oi_rdata_reg;
        end else begin
            send_byte = sum_reg;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iofe_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    unique case (q_head.op)
                        iofe_pkg::OP_SET:  state_next = iofe_pkg::ST_SET_WR;
                        iofe_pkg::OP_READ: state_next = iofe_pkg::ST_READ_RESP;
                        iofe_pkg::OP_SEND: state_next = iofe_pkg::ST_SEND;
                        iofe_pkg::OP_END:  state_next = (end_status == iofe_pkg::STS_OK)
                                                        ? iofe_pkg::ST_COMMIT
                                                        : iofe_pkg::ST_STATUS;
                        default:           state_next = iofe_pkg::ST_IDLE;
                    endcase
                end
            end
            iofe_pkg::ST_SET_WR: state_next = iofe_pkg::ST_IDLE;
            iofe_pkg::ST_READ_RESP: begin
                if (out_free) state_next = iofe_pkg::ST_IDLE;
            end
            iofe_pkg::ST_SEND: begin
                if (out_free && send_last) state_next = iofe_pkg::ST_IDLE;
            end
            iofe_pkg::ST_COMMIT: begin
                if (copy_idx_reg == copy_len_reg && !wr_pend_reg) begin
                    state_next = iofe_pkg::ST_STATUS;
                end
            end
            iofe_pkg::ST_STATUS: begin
                if (out_free) state_next = iofe_pkg::ST_IDLE;
            end
            default: state_next = iofe_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        q_pop      = 1'b0;
        oi_rd_en   = 1'b0;
        oi_rd_addr = IMG_AW'(q_head.byte_num);
        ii_rd_en   = 1'b0;
        ii_rd_addr = IMG_AW'(q_head.byte_num);
        oi_wr_en   = 1'b0;
        oi_wr_addr = IMG_AW'(cmd_reg.byte_num);
        oi_wr_data = cmd_reg.bit_value ? (oi_rdata_reg | bit_mask)
                                       : (oi_rdata_reg & ~bit_mask);
        sh_rd_en   = 1'b0;
        sh_rd_addr = SH_AW'(ANSWER_HEADER_BYTES) + SH_AW'(copy_idx_reg);
        sh_wr_en   = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        unique case (state_reg)
            iofe_pkg::ST_IDLE: begin
                q_pop = !q_empty;
                if (!q_empty) begin
                    oi_rd_en = (q_head.op == iofe_pkg::OP_SET) && q_head.in_range;
                    ii_rd_en = (q_head.op == iofe_pkg::OP_READ) && q_head.in_range;
                    sh_wr_en = head_is_rxb && (rx_cnt_reg < CNT_W'(SHADOW_DEPTH));
                end
            end
            iofe_pkg::ST_SET_WR: begin
                oi_wr_en = cmd_reg.in_range;
            end
            iofe_pkg::ST_READ_RESP: begin
                res_push          = out_free;
                res.result_kind   = iofe_pkg::RK_BIT;
                res.input_value   = cmd_reg.in_range && ii_rdata_reg[cmd_reg.bit_sel];
            end
            iofe_pkg::ST_SEND: begin
                res_push        = out_free;
                res.result_kind = iofe_pkg::RK_TX;
                res.tx_byte     = send_byte;
                res.tx_last     = send_last;
                // Fetch the next image byte while the current one is delivered.
                oi_rd_addr = IMG_AW'(pos_inc - POS_W'(iofe_pkg::REQ_HDR_BYTES));
                oi_rd_en   = out_free && (pos_inc >= POS_W'(iofe_pkg::REQ_HDR_BYTES))
                             && (pos_inc < data_end);
            end
            iofe_pkg::ST_COMMIT: begin
                sh_rd_en = (copy_idx_reg < copy_len_reg);
            end
            iofe_pkg::ST_STATUS: begin
                res_push        = out_free;
                res.result_kind = iofe_pkg::RK_STATUS;
                res.rx_status   = status_reg;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= iofe_pkg::ST_IDLE;
            rx_cnt_reg    <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_pend_reg <= sh_rd_en;
            if (state_reg == iofe_pkg::ST_IDLE && head_is_end) begin
                rx_cnt_reg <= '0;
            end else if (state_reg == iofe_pkg::ST_IDLE && head_is_rxb
                         && rx_cnt_reg < CNT_W'(SHADOW_DEPTH + 1)) begin
                rx_cnt_reg <= rx_cnt_reg + CNT_W'(1);
            end
            if (res_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_head;
        end
        if (state_reg == iofe_pkg::ST_IDLE && head_is_send) begin
            pos_reg <= '0;
            sum_reg <= '0;
        end else if (state_reg == iofe_pkg::ST_SEND && out_free) begin
            pos_reg <= pos_inc;
            sum_reg <= sum_reg + send_byte;
        end
        if (state_reg == iofe_pkg::ST_IDLE && head_is_rxb) begin
            if (rx_cnt_reg == CNT_W'(0)) first_reg <= q_head.rx_byte;
            if (rx_cnt_reg == CNT_W'(3)) addr_reg  <= q_head.rx_byte;
        end
        if (state_reg == iofe_pkg::ST_IDLE && head_is_end) begin
            status_reg   <= end_status;
            copy_len_reg <= in_size;
            copy_idx_reg <= '0;
        end else if (sh_rd_en) begin
            copy_idx_reg <= copy_idx_reg + SIZE_W'(1);
        end
        if (sh_rd_en) begin
            wr_idx_reg <= IMG_AW'(copy_idx_reg);
        end
        if (res_push) begin
            out_reg <= res;
        end
    end

    // Output image: valid bits make unwritten bytes read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_IMAGE_BYTES; i++) oi_vld_reg[i] <= 1'b0;
        end else if (oi_wr_en) begin
            oi_vld_reg[oi_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (oi_wr_en) begin
            oi_mem[oi_wr_addr] <= oi_wr_data;
        end
        if (oi_rd_en) begin
            oi_rdata_reg <= oi_vld_reg[oi_rd_addr] ? oi_mem[oi_rd_addr] : 8'd0;
        end
    end

    // Accepted input image, written by the commit copy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_IMAGE_BYTES; i++) ii_vld_reg[i] <= 1'b0;
        end else if (wr_pend_reg) begin
            ii_vld_reg[wr_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            ii_mem[wr_idx_reg] <= sh_rdata_reg;
        end
        if (ii_rd_en) begin
            ii_rdata_reg <= ii_vld_reg[ii_rd_addr] ? ii_mem[ii_rd_addr] : 8'd0;
        end
    end

    // Receive shadow buffer.
    always_ff @(posedge aclk) begin
        if (sh_wr_en) begin
            sh_mem[SH_AW'(rx_cnt_reg)] <= q_head.rx_byte;
        end
        if (sh_rd_en) begin
            sh_rdata_reg <= sh_mem[sh_rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    `IOFE_ASSERT_NOW(a_last_only_tx, aclk, aresetn,
        out_valid_reg && out_reg.tx_last, out_reg.result_kind == iofe_pkg::RK_TX,
        "frame end mark on a result that is not a transmit byte")
    `IOFE_ASSERT_NOW(a_rx_cnt_bound, aclk, aresetn,
        1'b1, rx_cnt_reg <= CNT_W'(SHADOW_DEPTH + 1),
        "receive count beyond its saturation value")
    `IOFE_ASSERT_NOW(a_copy_bound, aclk, aresetn,
        state_reg == iofe_pkg::ST_COMMIT, copy_idx_reg <= copy_len_reg,
        "commit copy ran past the answer image size")
    `IOFE_ASSERT_NOW(a_no_overwrite, aclk, aresetn,
        res_push, out_free,
        "result written over one not yet taken")
    `IOFE_ASSERT_NEXT(a_send_ends_idle, aclk, aresetn,
        state_reg == iofe_pkg::ST_SEND && out_free && send_last,
        state_reg == iofe_pkg::ST_IDLE,
        "sequencer did not return to idle after the checksum byte")

endmodule

`default_nettype wire

// File: design/io_process_image_frame_engine.sv
// Top level of the I/O bus coupler frame engine: configuration registers and stream ports.
// A request waits in the command queue until the back end takes it. A bit set rewrites
// its image byte. A send streams 4 + image bytes + 1 frame bytes at one per cycle unless
// results stall, reading one byte ahead. A rejected burst end reports its status directly;
// an accepted one first copies the answer image in. Synchronous reset clears the
// configuration registers, both images and the receive count.
`default_nettype none

module io_process_image_frame_engine #(
    parameter int MAX_IMAGE_BYTES     = 16,
    parameter int ANSWER_HEADER_BYTES = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,

    // Input requests.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // bit_index[6:0], bit_value[7], rx_byte[15:8]
    input  wire logic [2:0]  s_tuser,   // kind[2:0]

    // Result requests.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // tx_byte[7:0], input_value[8], rx_status[11:9], zero
    output logic             m_tlast,   // tx_last
    output logic [1:0]       m_tuser    // result_kind[1:0]
);

    // The configuration must be written only while the engine is idle, so the back end may
    // read it combinationally without any capture; the block itself does not enforce this.
    iofe_pkg::cfg_t    cfg_reg;
    iofe_pkg::cmd_t    push_cmd, head_cmd;
    iofe_pkg::result_t result;
    logic              q_push, q_pop, q_full, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                iofe_pkg::CFG_OUTPUT_COUNT:    cfg_reg.output_count    <= cfg_wdata;
                iofe_pkg::CFG_INPUT_COUNT:     cfg_reg.input_count     <= cfg_wdata;
                iofe_pkg::CFG_COUPLER_ADDRESS: cfg_reg.coupler_address <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The front end classifies each request and drops kinds that have no meaning.
    iofe_front #(
        .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // The queue lets the front keep taking requests while the back end works or stalls.
    iofe_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // The back end owns the images and the shadow buffer and produces all results.
    iofe_back #(
        .MAX_IMAGE_BYTES    (MAX_IMAGE_BYTES),
        .ANSWER_HEADER_BYTES(ANSWER_HEADER_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_result (result)
    );

    assign m_tdata = {4'd0, result.rx_status, result.input_value, result.tx_byte};
    assign m_tlast = result.tx_last;
    assign m_tuser = result.result_kind;

endmodule

`default_nettype wire

// File: tb/io_process_image_frame_engine_test.sv
// Self-checking testbench for the I/O bus coupler frame engine: directed table, then random traffic.
`default_nettype none

module io_process_image_frame_engine_test;

    // Sizes match the defaults of the engine.
    localparam int MAX_IMAGE_BYTES     = 16;
    localparam int ANSWER_HEADER_BYTES = 4;
    localparam int SHADOW_DEPTH        = ANSWER_HEADER_BYTES + MAX_IMAGE_BYTES + 1;
    localparam int IMAGE_CAP           = MAX_IMAGE_BYTES & ~1;
    localparam int ANSWER_ADDRESS_POS  = 3;

    // Short local names for the shared codes.
    typedef iofe_pkg::result_t result_t;
    localparam logic [2:0] KIND_SET  = iofe_pkg::KIND_SET;
    localparam logic [2:0] KIND_READ = iofe_pkg::KIND_READ;
    localparam logic [2:0] KIND_SEND = iofe_pkg::KIND_SEND;
    localparam logic [2:0] KIND_RXB  = iofe_pkg::KIND_RXB;
    localparam logic [2:0] KIND_END  = iofe_pkg::KIND_END;
    localparam logic [1:0] RK_TX     = iofe_pkg::RK_TX;
    localparam logic [1:0] RK_BIT    = iofe_pkg::RK_BIT;
    localparam logic [1:0] RK_STATUS = iofe_pkg::RK_STATUS;
    localparam logic [2:0] STS_OK    = iofe_pkg::STS_OK;
    localparam logic [2:0] STS_EMPTY = iofe_pkg::STS_EMPTY;
    localparam logic [2:0] STS_LEN   = iofe_pkg::STS_LEN;
    localparam logic [2:0] STS_TYPE  = iofe_pkg::STS_TYPE;
    localparam logic [2:0] STS_ADDR  = iofe_pkg::STS_ADDR;
    localparam logic [1:0] CFG_OUTPUT_COUNT    = iofe_pkg::CFG_OUTPUT_COUNT;
    localparam logic [1:0] CFG_INPUT_COUNT     = iofe_pkg::CFG_INPUT_COUNT;
    localparam logic [1:0] CFG_COUPLER_ADDRESS = iofe_pkg::CFG_COUPLER_ADDRESS;
    localparam logic [7:0] CH_REQUEST = iofe_pkg::CH_REQUEST;
    localparam logic [7:0] CH_ANSWER  = iofe_pkg::CH_ANSWER;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] CFG_SPARE_INDEX  = 2'd3;
    localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;
    localparam logic [2:0] KIND_LAST_SPARE  = 3'd7;

    localparam int          SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS    = 40;
    localparam logic [7:0]  DIRECTED_ADDRESS = 8'hFF;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] bit_index;
        logic       bit_value;
        logic [7:0] rx_byte;
    } request_t;

    // One line of the directed table. When pinned is set, the outcome column is the
    // result to compare against instead of the predicted one.
    typedef struct packed {
        request_t req;
        logic     pinned;
        result_t  outcome;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    io_process_image_frame_engine #(
        .MAX_IMAGE_BYTES    (MAX_IMAGE_BYTES),
        .ANSWER_HEADER_BYTES(ANSWER_HEADER_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Shadow copy of the engine: registers, both images and the answer buffer.
    logic [7:0]  out_points   = '0;
    logic [7:0]  in_points    = '0;
    logic [7:0]  coupler_addr = '0;
    logic [7:0]  sent_image     [MAX_IMAGE_BYTES] = '{default: '0};
    logic [7:0]  accepted_image [MAX_IMAGE_BYTES] = '{default: '0};
    logic [7:0]  answer_shadow  [SHADOW_DEPTH]    = '{default: '0};
    int unsigned answer_length = 0;

    result_t     results_due [$];
    stim_row_t   directed_table [25];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned quiet_cycles   = 0;
    bit          failed         = 1'b0;

    // Image size in bytes for a point count: whole 16-bit words, capped at the storage.
    function automatic int unsigned coupler_image_bytes(input logic [7:0] points);
        int unsigned n;
        n = ((int'(points) + 7) / 8 + 1) & ~32'd1;
        return (n > IMAGE_CAP) ? IMAGE_CAP : n;
    endfunction

    // Updates the shadow state for one accepted request and queues the results it causes.
    task automatic predict_coupler_results(input request_t r);
        int unsigned byte_no;
        int unsigned size;
        logic [7:0]  checksum;
        logic [7:0]  frame [$];
        result_t     res;
        byte_no = int'(r.bit_index) >> 3;
        res = '0;
        unique case (r.kind)
            KIND_SET: begin
                if (byte_no < MAX_IMAGE_BYTES)
                    sent_image[byte_no][r.bit_index[2:0]] = r.bit_value;
            end
            KIND_READ: begin
                res.result_kind = RK_BIT;
                if (byte_no < MAX_IMAGE_BYTES)
                    res.input_value = accepted_image[byte_no][r.bit_index[2:0]];
                results_due.push_back(res);
            end
            KIND_SEND: begin
                // Header, image bytes, then the running sum with the last flag.
                size = coupler_image_bytes(out_points);
                frame = {CH_REQUEST, 8'(size / 2), coupler_addr, coupler_addr};
                for (int i = 0; i < size; i++)
                    frame.push_back(sent_image[i]);
                checksum = '0;
                res.result_kind = RK_TX;
                foreach (frame[i]) begin
                    res.tx_byte = frame[i];
                    checksum += frame[i];
                    results_due.push_back(res);
                end
                res.tx_byte = checksum;
                res.tx_last = 1'b1;
                results_due.push_back(res);
            end
            KIND_RXB: begin
                // Bytes past the shadow are dropped; the count stops one above it.
                if (answer_length < SHADOW_DEPTH)
                    answer_shadow[answer_length] = r.rx_byte;
                if (answer_length < SHADOW_DEPTH + 1)
                    answer_length++;
            end
            KIND_END: begin
                size = coupler_image_bytes(in_points);
                res.result_kind = RK_STATUS;
                if (answer_length == 0)
                    res.rx_status = STS_EMPTY;
                else if (answer_length != ANSWER_HEADER_BYTES + size + 1)
                    res.rx_status = STS_LEN;
                else if (answer_shadow[0] != CH_ANSWER)
                    res.rx_status = STS_TYPE;
                else if (answer_shadow[ANSWER_ADDRESS_POS] != coupler_addr)
                    res.rx_status = STS_ADDR;
                else begin
                    res.rx_status = STS_OK;
                    for (int i = 0; i < size; i++)
                        accepted_image[i] = answer_shadow[ANSWER_HEADER_BYTES + i];
                end
                answer_length = 0;
                results_due.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic stim_row_t dir_row(input logic [2:0] kind, input logic [6:0] idx,
                                          input logic val, input logic [7:0] rxb,
                                          input logic pin, input logic [1:0] rkind,
                                          input logic bitv, input logic [2:0] status);
        stim_row_t row;
        row.req     = '{kind: kind, bit_index: idx, bit_value: val, rx_byte: rxb};
        row.pinned  = pin;
        row.outcome = '0;
        row.outcome.result_kind = rkind;
        row.outcome.input_value = bitv;
        row.outcome.rx_status   = status;
        return row;
    endfunction

    function automatic request_t random_request(input logic [2:0] kind);
        request_t r;
        r.kind      = kind;
        r.bit_index = 7'($urandom_range(0, 127));
        r.bit_value = 1'($urandom_range(0, 1));
        r.rx_byte   = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // Presents one request, with random idle cycles ahead of it, and waits for acceptance.
    // Valid stays high on return so that back-to-back requests leave no gap.
    task automatic drive_request(input request_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {r.rx_byte, r.bit_value, r.bit_index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (r.kind <= KIND_END)
            items_sent++;
        predict_coupler_results(r);
    endtask

    // Writes all three registers and the unused index, one per cycle.
    task automatic program_coupler(input logic [7:0] outputs, input logic [7:0] inputs,
                                   input logic [7:0] address);
        logic [1:0] indexes [4];
        logic [7:0] values  [4];
        indexes = '{CFG_OUTPUT_COUNT, CFG_INPUT_COUNT, CFG_COUPLER_ADDRESS, CFG_SPARE_INDEX};
        values  = '{outputs, inputs, address, 8'($urandom_range(0, 255))};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= indexes[i];
            cfg_wdata <= values[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        out_points   = outputs;
        in_points    = inputs;
        coupler_addr = address;
    endtask

    // Stops the input stream, waits for every outstanding result and then lets
    // requests that produce nothing finish inside the engine.
    task automatic settle_engine();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random traffic. Most of the receive side is answer bursts of the right shape with
    // random content; some carry a bad type byte, a bad address or a wrong length (long
    // ones run past the shadow buffer). Short noise bursts include empty ones.
    task automatic run_random_traffic(input int unsigned quota);
        int unsigned goal;
        int unsigned pick;
        int unsigned len;
        int unsigned good_len;
        int unsigned flaw;
        request_t    r;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                drive_request(random_request(KIND_SET));
            end else if (pick < 48) begin
                drive_request(random_request(KIND_READ));
            end else if (pick < 56) begin
                drive_request(random_request(KIND_SEND));
            end else if (pick < 88) begin
                good_len = ANSWER_HEADER_BYTES + coupler_image_bytes(in_points) + 1;
                flaw = $urandom_range(0, 99);
                len  = good_len;
                if (flaw < 12) begin
                    do len = $urandom_range(1, SHADOW_DEPTH + 3); while (len == good_len);
                end
                for (int i = 0; i < len; i++) begin
                    r = random_request(KIND_RXB);
                    if (i == 0) begin
                        if (flaw >= 12 && flaw < 24) begin
                            if (r.rx_byte == CH_ANSWER) r.rx_byte = ~r.rx_byte;
                        end else
                            r.rx_byte = CH_ANSWER;
                    end
                    if (i == ANSWER_ADDRESS_POS) begin
                        if (flaw >= 24 && flaw < 36) begin
                            if (r.rx_byte == coupler_addr) r.rx_byte = ~r.rx_byte;
                        end else
                            r.rx_byte = coupler_addr;
                    end
                    drive_request(r);
                end
                drive_request(random_request(KIND_END));
            end else if (pick < 95) begin
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++)
                    drive_request(random_request(KIND_RXB));
                drive_request(random_request(KIND_END));
            end else begin
                drive_request(random_request(3'($urandom_range(KIND_FIRST_SPARE,
                                                               KIND_LAST_SPARE))));
            end
        end
    endtask

    // Result side: compares each accepted result with the oldest expectation and
    // redraws the ready line every cycle.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result: kind %0d data %h last %b", m_tuser, m_tdata, m_tlast);
                failed = 1'b1;
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.result_kind) begin
                    $error("result_kind: expected %0d, got %0d", want.result_kind, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[7:0] !== want.tx_byte) begin
                    $error("tx_byte: expected %h, got %h", want.tx_byte, m_tdata[7:0]);
                    failed = 1'b1;
                end
                if (m_tlast !== want.tx_last) begin
                    $error("tx_last: expected %b, got %b", want.tx_last, m_tlast);
                    failed = 1'b1;
                end
                if (m_tdata[8] !== want.input_value) begin
                    $error("input_value: expected %b, got %b", want.input_value, m_tdata[8]);
                    failed = 1'b1;
                end
                if (m_tdata[11:9] !== want.rx_status) begin
                    $error("rx_status: expected %0d, got %0d", want.rx_status, m_tdata[11:9]);
                    failed = 1'b1;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a long run of cycles with no request moving on either side is a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned send_idle_by_phase [4];
        int unsigned recv_stall_by_phase [4];
        send_idle_by_phase  = '{0, 51, 0, 13};
        recv_stall_by_phase = '{0, 0, 51, 13};

        // Directed part, run with the widest output image, no answer image and the
        // top address. Every read and status in the table is typed in.
        directed_table = '{
            dir_row(KIND_READ, 7'd0,   1'b0, 8'h00, 1'b1, RK_BIT, 1'b0, STS_OK),
            dir_row(KIND_READ, 7'd127, 1'b1, 8'hFF, 1'b1, RK_BIT, 1'b0, STS_OK),
            dir_row(KIND_END,  7'd0,   1'b0, 8'h00, 1'b1, RK_STATUS, 1'b0, STS_EMPTY),
            dir_row(KIND_SET,  7'd0,   1'b1, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_SET,  7'd127, 1'b1, 8'hFF, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_SET,  7'd77,  1'b1, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_SET,  7'd77,  1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_SEND, 7'd0,   1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            // A burst that is too short.
            dir_row(KIND_RXB,  7'd0,   1'b0, CH_ANSWER, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'hFF, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_END,  7'd0,   1'b0, 8'h00, 1'b1, RK_STATUS, 1'b0, STS_LEN),
            // A well-formed answer with an empty image.
            dir_row(KIND_RXB,  7'd0,   1'b0, CH_ANSWER, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, DIRECTED_ADDRESS, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'h5A, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_END,  7'd0,   1'b0, 8'h00, 1'b1, RK_STATUS, 1'b0, STS_OK),
            // Right length and type, wrong address.
            dir_row(KIND_RXB,  7'd0,   1'b0, CH_ANSWER, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'hFE, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_RXB,  7'd0,   1'b0, 8'h00, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_END,  7'd0,   1'b0, 8'h00, 1'b1, RK_STATUS, 1'b0, STS_ADDR),
            // An unused kind changes nothing, so the input image still reads zero.
            dir_row(KIND_LAST_SPARE, 7'd127, 1'b1, 8'hFF, 1'b0, RK_TX, 1'b0, STS_OK),
            dir_row(KIND_READ, 7'd127, 1'b0, 8'h00, 1'b1, RK_BIT, 1'b0, STS_OK)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        program_coupler(8'd128, 8'd0, DIRECTED_ADDRESS);

        foreach (directed_table[i]) begin
            drive_request(directed_table[i].req);
            if (directed_table[i].pinned) begin
                void'(results_due.pop_back());
                results_due.push_back(directed_table[i].outcome);
            end
        end
        settle_engine();

        // Random phases, each with its own idling pattern and register setting.
        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0:       program_coupler(8'd0, 8'd0, 8'd0);
                1:       program_coupler(8'd128, 8'd128, 8'hFF);
                2:       program_coupler(8'($urandom_range(0, 128)), 8'($urandom_range(0, 24)),
                                         8'($urandom_range(0, 255)));
                default: program_coupler(8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)),
                                         8'($urandom_range(0, 255)));
            endcase
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            run_random_traffic(PHASE_ITEMS);
            settle_engine();
        end

        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
